// File: src/prb_pkg.sv
`default_nettype none

package prb_pkg;

    // Fixed field widths
    localparam int FIELD_W = 6;
    localparam int WORD_W  = 32;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_NEXT  = 5'b00010,
        S_FIRST = 5'b00100,
        S_SUM   = 5'b01000,
        S_LOOK  = 5'b10000
    } state_t;

    // Controls from the sequencer to the row store
    typedef struct packed {
        logic rd_en;      // issue a read, data follows in the next cycle
        logic wr_en;      // write this cycle
        logic wr_one;     // write the constant 1, else the saturated sum
        logic load_hold;  // keep the last read word for the next add
    } store_ctrl_t;

endpackage

`default_nettype wire

// File: src/prb_row_store.sv
`default_nettype none

module prb_row_store #(
    parameter int DEPTH  = 33,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire prb_pkg::store_ctrl_t        ctrl,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    output logic      [prb_pkg::WORD_W-1:0]  rd_data
);

    logic [prb_pkg::WORD_W-1:0] mem [DEPTH];
    logic [prb_pkg::WORD_W-1:0] rd_data_reg;
    logic [prb_pkg::WORD_W-1:0] hold_reg;
    logic [prb_pkg::WORD_W:0]   sum_wide;
    logic [prb_pkg::WORD_W-1:0] wr_data;

    // Saturating add of the held word and its left neighbour
    assign sum_wide = {1'b0, hold_reg} + {1'b0, rd_data_reg};

    always_comb
    begin
        if (ctrl.wr_one)
        begin
            wr_data = prb_pkg::WORD_W'(1);
        end
        else if (sum_wide[prb_pkg::WORD_W])
        begin
            wr_data = '1;
        end
        else
        begin
            wr_data = sum_wide[prb_pkg::WORD_W-1:0];
        end
    end

    // Row memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Held copy of the old value of the entry that the add result overwrites
    always_ff @(posedge clk)
    begin
        if (ctrl.load_hold)
        begin
            hold_reg <= rd_data_reg;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/pascal_row_binomial_unit.sv
// Channel   Signals                              Handshake
// -------   ----------------------------------   -----------------------------------
// input     row_number, column_number            start high while busy low
// result    coefficient, range_error             done strobe, one cycle, no stall
//
// Each in-place add reads one word through the single read port of the row memory.
// Rows past MAX_ROW saturate to MAX_ROW. Reset clears the sequencer, the row and
// column registers and the done strobe; the row memory needs no clearing since
// entry 0 is written first.
// The receiver cannot stall; busy holds off the next transaction until done.
`default_nettype none

module pascal_row_binomial_unit #(
    parameter int MAX_ROW = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [prb_pkg::FIELD_W-1:0]  row_number,
    input  wire logic [prb_pkg::FIELD_W-1:0]  column_number,
    output logic                              done,
    output logic      [prb_pkg::WORD_W-1:0]   coefficient,
    output logic                              range_error
);

    localparam int DEPTH  = MAX_ROW + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    prb_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0]           row_reg, row_next;
    logic [ADDR_W-1:0]           target_reg, target_next;
    logic [ADDR_W-1:0]           idx_reg, idx_next;
    logic [prb_pkg::FIELD_W-1:0] column_reg, column_next;
    logic                        done_reg, done_next;
    logic [prb_pkg::WORD_W-1:0]  coefficient_reg, coefficient_next;
    logic                        range_error_reg, range_error_next;

    prb_pkg::store_ctrl_t        ctrl;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic [prb_pkg::WORD_W-1:0]  rd_data;
    logic [ADDR_W-1:0]           row_inc;
    logic [ADDR_W-1:0]           n_sat;
    logic                        col_error;

    // Clamp requested row to the top of the store
    assign n_sat = (row_number > prb_pkg::FIELD_W'(MAX_ROW))
                 ? ADDR_W'(MAX_ROW) : row_number[ADDR_W-1:0];
    assign row_inc   = row_reg + ADDR_W'(1);
    assign col_error = column_reg > prb_pkg::FIELD_W'(target_reg);

    // Sequencer: rows are built high index down, so every read address sits
    // below the write address of the same cycle and no forwarding is needed
    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        target_next      = target_reg;
        idx_next         = idx_reg;
        column_next      = column_reg;
        done_next        = 1'b0;
        coefficient_next = coefficient_reg;
        range_error_next = range_error_reg;
        ctrl             = '0;
        rd_addr          = idx_reg;
        wr_addr          = idx_reg;

        case (state_reg)
            prb_pkg::S_IDLE:
            begin
                if (start)
                begin
                    target_next = n_sat;
                    column_next = column_number;
                    row_next    = '0;
                    ctrl.wr_en  = 1'b1;
                    ctrl.wr_one = 1'b1;
                    wr_addr     = '0;
                    state_next  = prb_pkg::S_NEXT;
                end
            end
            prb_pkg::S_NEXT:
            begin
                if (row_reg == target_reg)
                begin
                    ctrl.rd_en = !col_error;
                    rd_addr    = column_reg[ADDR_W-1:0];
                    state_next = prb_pkg::S_LOOK;
                end
                else
                begin
                    // trailing 1 of the new row goes in now
                    ctrl.wr_en  = 1'b1;
                    ctrl.wr_one = 1'b1;
                    wr_addr     = row_inc;
                    row_next    = row_inc;
                    if (row_inc != ADDR_W'(1))
                    begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = row_reg;
                        idx_next   = row_reg;
                        state_next = prb_pkg::S_FIRST;
                    end
                end
            end
            prb_pkg::S_FIRST:
            begin
                ctrl.load_hold = 1'b1;
                ctrl.rd_en     = 1'b1;
                rd_addr        = idx_reg - ADDR_W'(1);
                state_next     = prb_pkg::S_SUM;
            end
            prb_pkg::S_SUM:
            begin
                ctrl.wr_en     = 1'b1;
                wr_addr        = idx_reg;
                ctrl.load_hold = 1'b1;
                if (idx_reg == ADDR_W'(1))
                begin
                    state_next = prb_pkg::S_NEXT;
                end
                else
                begin
                    ctrl.rd_en = 1'b1;
                    rd_addr    = idx_reg - ADDR_W'(2);
                    idx_next   = idx_reg - ADDR_W'(1);
                end
            end
            prb_pkg::S_LOOK:
            begin
                done_next        = 1'b1;
                range_error_next = col_error;
                coefficient_next = col_error ? '0 : rd_data;
                state_next       = prb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = prb_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= prb_pkg::S_IDLE;
            row_reg    <= '0;
            column_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            column_reg <= column_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        target_reg      <= target_next;
        idx_reg         <= idx_next;
        coefficient_reg <= coefficient_next;
        range_error_reg <= range_error_next;
    end

    prb_row_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .rd_data (rd_data)
    );

    assign busy        = (state_reg != prb_pkg::S_IDLE);
    assign done        = done_reg;
    assign coefficient = coefficient_reg;
    assign range_error = range_error_reg;

endmodule

`default_nettype wire

// File: src/prb_checker.sv
`default_nettype none

module prb_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic                         done,
    input  wire logic [prb_pkg::WORD_W-1:0]   coefficient,
    input  wire logic                         range_error
);

    // An accepted transaction makes the unit busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("unit not busy after accepting a transaction");

    // A result appears only once the work is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe without preceding work");

    // The strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Out-of-range column gives a zero coefficient
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && range_error |-> coefficient == '0)
        else $error("range error with nonzero coefficient");

endmodule

bind pascal_row_binomial_unit prb_checker u_prb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .coefficient (coefficient),
    .range_error (range_error)
);

`default_nettype wire

// File: bench/pascal_row_binomial_unit_test.sv
`default_nettype none

module pascal_row_binomial_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LIMIT    = 32;
    localparam int RANDOM_ITEMS = 1000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 600;

    // One request: triangle row and column
    typedef struct {
        logic [prb_pkg::FIELD_W-1:0] row;
        logic [prb_pkg::FIELD_W-1:0] column;
    } coord_t;

    // One predicted answer, with the request kept for reporting
    typedef struct {
        logic [prb_pkg::FIELD_W-1:0] row;
        logic [prb_pkg::FIELD_W-1:0] column;
        logic [prb_pkg::WORD_W-1:0]  coefficient;
        logic                        range_error;
    } binomial_t;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        start         = 1'b0;
    logic [prb_pkg::FIELD_W-1:0] row_number    = '0;
    logic [prb_pkg::FIELD_W-1:0] column_number = '0;
    logic                        busy;
    logic                        done;
    logic [prb_pkg::WORD_W-1:0]  coefficient;
    logic                        range_error;

    coord_t    queued_coords[$];
    binomial_t owed_coefficients[$];
    int        accepted_count = 0;
    int        total_items    = 0;
    int        fail_count     = 0;

    pascal_row_binomial_unit #(
        .MAX_ROW(ROW_LIMIT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .row_number   (row_number),
        .column_number(column_number),
        .done         (done),
        .coefficient  (coefficient),
        .range_error  (range_error)
    );

    always #5 clk = ~clk;

    // Builds Pascal's triangle up to the clamped row and picks the column
    function automatic binomial_t pascal_entry(input logic [prb_pkg::FIELD_W-1:0] n_in,
                                               input logic [prb_pkg::FIELD_W-1:0] k_in);
        logic [prb_pkg::WORD_W-1:0] row_words[0:ROW_LIMIT];
        logic [prb_pkg::WORD_W:0]   sum;
        binomial_t                  answer;
        int                         top;
        top = (n_in > ROW_LIMIT) ? ROW_LIMIT : int'(n_in);
        row_words[0] = 1;
        for (int r = 1; r <= top; r++)
        begin
            // in place, high index down; sums clip at all ones
            for (int i = r - 1; i > 0; i--)
            begin
                sum = {1'b0, row_words[i]} + {1'b0, row_words[i-1]};
                row_words[i] = sum[prb_pkg::WORD_W] ? '1 : sum[prb_pkg::WORD_W-1:0];
            end
            row_words[r] = 1;
        end
        answer.row    = n_in;
        answer.column = k_in;
        if (int'(k_in) > top)
        begin
            answer.coefficient = '0;
            answer.range_error = 1'b1;
        end
        else
        begin
            answer.coefficient = row_words[k_in];
            answer.range_error = 1'b0;
        end
        return answer;
    endfunction

    task automatic note_mismatch(input string what);
        if (fail_count < REPORT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    // Command driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        coord_t item;
        logic   offered;
        int     burst_left;
        int     gap_left;
        if (!rst_n)
        begin
            start         <= 1'b0;
            row_number    <= '0;
            column_number <= '0;
            burst_left    = 4;
            gap_left      = 0;
        end
        else
        begin
            offered = start;
            // accepted transaction: predict its answer
            if (start && !busy)
            begin
                owed_coefficients.insert(owed_coefficients.size(),
                                         pascal_entry(row_number, column_number));
                accepted_count++;
                offered = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 20);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 3);
                        2: gap_left = $urandom_range(4, 20);
                        default: gap_left = $urandom_range(0, 1);
                    endcase
                end
            end
            // hold an unaccepted request, else offer the next one or idle
            if (!offered)
            begin
                if (gap_left > 0 || queued_coords.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    start         <= 1'b0;
                    row_number    <= prb_pkg::FIELD_W'($urandom);
                    column_number <= prb_pkg::FIELD_W'($urandom);
                end
                else
                begin
                    item = queued_coords.pop_front();
                    start         <= 1'b1;
                    row_number    <= item.row;
                    column_number <= item.column;
                end
            end
        end
    end

    // Result monitor: every done strobe is checked against the oldest prediction
    always @(posedge clk)
    begin : check_results
        binomial_t want;
        if (rst_n && done)
        begin
            if (owed_coefficients.size() == 0)
                note_mismatch($sformatf("result with nothing pending: coef=%0d err=%0b",
                                        coefficient, range_error));
            else
            begin
                want = owed_coefficients.pop_front();
                if (coefficient !== want.coefficient || range_error !== want.range_error)
                    note_mismatch($sformatf(
                        "C(%0d,%0d): expected coef=%0d err=%0b, got coef=%0d err=%0b",
                        want.row, want.column, want.coefficient, want.range_error,
                        coefficient, range_error));
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        coord_t    c;
        int        pick;
        int        n;
        // extremes, clamped rows, out-of-range columns
        static int directed[24][2] = '{
            '{0, 0}, '{0, 1}, '{1, 0}, '{1, 1}, '{1, 2}, '{2, 1}, '{2, 2}, '{3, 0},
            '{32, 0}, '{32, 16}, '{32, 32}, '{32, 33}, '{31, 15}, '{33, 5},
            '{63, 63}, '{63, 32}, '{63, 33}, '{40, 32}, '{0, 63}, '{32, 63},
            '{5, 6}, '{10, 3}, '{17, 8}, '{63, 0}
        };
        foreach (directed[i])
        begin
            c.row    = prb_pkg::FIELD_W'(directed[i][0]);
            c.column = prb_pkg::FIELD_W'(directed[i][1]);
            queued_coords.insert(queued_coords.size(), c);
        end
        // random part, mostly short rows to keep the run quick
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n = $urandom_range(0, 12);
            else if (pick < 85)
                n = $urandom_range(13, ROW_LIMIT);
            else
                n = $urandom_range(0, 63);
            c.row = prb_pkg::FIELD_W'(n);
            if (pick >= 95)
                c.column = prb_pkg::FIELD_W'($urandom);
            else if (n > ROW_LIMIT)
                c.column = prb_pkg::FIELD_W'($urandom_range(0, ROW_LIMIT + 1));
            else
                c.column = prb_pkg::FIELD_W'($urandom_range(0, n + 1));
            queued_coords.insert(queued_coords.size(), c);
        end
        total_items = queued_coords.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items || owed_coefficients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/prb_pkg.sv
src/prb_row_store.sv
src/pascal_row_binomial_unit.sv
src/prb_checker.sv
bench/pascal_row_binomial_unit_test.sv
